### rtl/wera_pkg.sv
// ----------------------------------------------------------------------------
// wera_pkg: shared types and constants for the windowed event rate alarm
// Field widths, register indexes, calendar constants and the forwarding type.
// ----------------------------------------------------------------------------
`default_nettype none

package wera_pkg;

	localparam int TIME_W            = 25;   // absolute seconds in the year
	localparam int WIN_W             = 17;
	localparam int THR_W             = 11;
	localparam int DAY_W             = 9;    // day of year, 0..365
	localparam int HMS_W             = 17;   // seconds within a day incl. overflow
	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int FWD_CELLS         = 2;    // writes in flight past the ring read
	localparam int IN_TDATA_W        = 32;
	localparam int OUT_TDATA_W       = 8;
	localparam int CFG_IDX_W         = 1;

	localparam int SECS_PER_DAY  = 24 * 60 * 60;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;

	localparam logic [WIN_W-1:0] WINDOW_RESET    = WIN_W'(60);
	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

	// lookup result travelling down the forwarding cells
	typedef struct packed {
		logic              hit;
		logic [TIME_W-1:0] t;
	} fwd_t;

	// days before the month in 2012; month 0 reads as January, 13..15 as December
	function automatic logic [DAY_W-1:0] days_before_month(input logic [3:0] month);
		logic [DAY_W-1:0] d;
		case (month)
			4'd0, 4'd1: d = DAY_W'(0);
			4'd2:       d = DAY_W'(31);
			4'd3:       d = DAY_W'(60);
			4'd4:       d = DAY_W'(91);
			4'd5:       d = DAY_W'(121);
			4'd6:       d = DAY_W'(152);
			4'd7:       d = DAY_W'(182);
			4'd8:       d = DAY_W'(213);
			4'd9:       d = DAY_W'(244);
			4'd10:      d = DAY_W'(274);
			4'd11:      d = DAY_W'(305);
			default:    d = DAY_W'(335);
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/wera_ring.sv
// ----------------------------------------------------------------------------
// wera_ring: timestamp history ring
// One write port, one read port with registered read data; no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wera_ring #(
	parameter int DEPTH = wera_pkg::HISTORY_DEPTH_DEF,
	parameter int IW    = 10
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [IW-1:0]              waddr,
	input  wire logic [wera_pkg::TIME_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [IW-1:0]              raddr,
	output logic      [wera_pkg::TIME_W-1:0] rdata_s2
);

	logic [wera_pkg::TIME_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s2 <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/wera_cell.sv
// ----------------------------------------------------------------------------
// wera_cell: one forwarding cell
// Holds one recent ring write, shifts it on to the next cell on every write,
// and answers the lookup if no newer cell already has.
// ----------------------------------------------------------------------------
`default_nettype none

module wera_cell #(
	parameter int IW = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift,
	input  wire logic                        up_valid,
	input  wire logic [IW-1:0]               up_idx,
	input  wire logic [wera_pkg::TIME_W-1:0] up_time,
	output logic                             dn_valid,
	output logic      [IW-1:0]               dn_idx,
	output logic      [wera_pkg::TIME_W-1:0] dn_time,
	input  wire logic [IW-1:0]               lookup,
	input  wire wera_pkg::fwd_t              chain_in,
	output wera_pkg::fwd_t                   chain_out
);

	logic                        valid_q;
	logic [IW-1:0]               idx_q;
	logic [wera_pkg::TIME_W-1:0] t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			idx_q <= up_idx;
			t_q   <= up_time;
		end
	end

	assign dn_valid = valid_q;
	assign dn_idx   = idx_q;
	assign dn_time  = t_q;

	// newer cells sit earlier in the chain and win
	always_comb begin
		chain_out = chain_in;
		if (!chain_in.hit && valid_q && (idx_q == lookup)) begin
			chain_out.hit = 1'b1;
			chain_out.t   = t_q;
		end
	end

endmodule

`default_nettype wire

### rtl/windowed_event_rate_alarm.sv
// An input transfer passes through s1, s2, s3 and the output register before its result shows on m_tvalid.
// Throughput: one event per cycle while the output is not held off; the ring takes one read and one write a cycle.
// Backpressure stalls the whole pipe; s_tready follows m_tready and the output register.
// Reset (arst_n low): pipe empty, ring index and fill count zero, alarm not fired,
// window 60 s, threshold 1. Ring contents are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// windowed_event_rate_alarm: sliding window event rate threshold
// Converts calendar timestamps to seconds of the year, keeps a ring of recent
// times and reports whether the threshold-th most recent event is in window.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_event_rate_alarm #(
	parameter int HISTORY_DEPTH = wera_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [3:0] month, [8:4] day, [13:9] hour, [19:14] minute, [25:20] second
	input  wire logic [wera_pkg::IN_TDATA_W-1:0]    s_tdata,
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [0] reached, [1] first_reach
	output logic      [wera_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// configuration writes
	input  wire logic                               cfg_we,
	input  wire logic [wera_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wera_pkg::WIN_W-1:0]         cfg_wdata
);

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int XW = ((CW > wera_pkg::THR_W) ? CW : wera_pkg::THR_W) + 1;
	localparam int TW = wera_pkg::TIME_W;
	localparam int NC = wera_pkg::FWD_CELLS;

	// ---- handshake: one global advance for the whole pipe ----
	logic adv;
	logic accept;

	logic v_s1, v_s2, v_s3;
	logic m_tvalid_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// ---- configuration ----
	logic [wera_pkg::WIN_W-1:0] win_q;
	logic [wera_pkg::THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= wera_pkg::WINDOW_RESET;
			thr_q <= wera_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wera_pkg::REG_WINDOW:    win_q <= cfg_wdata;
				wera_pkg::REG_THRESHOLD: thr_q <= cfg_wdata[wera_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- accept: day of year, ring slot and read decision ----
	logic [3:0] in_month;
	logic [4:0] in_day;
	logic [4:0] in_hour;
	logic [5:0] in_minute;
	logic [5:0] in_second;

	assign in_month  = s_tdata[3:0];
	assign in_day    = s_tdata[8:4];
	assign in_hour   = s_tdata[13:9];
	assign in_minute = s_tdata[19:14];
	assign in_second = s_tdata[25:20];

	logic [IW-1:0]              wr_idx_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_nxt;
	logic [wera_pkg::THR_W-1:0] m_c;
	logic [XW-1:0]              mm1;
	logic [XW-1:0]              slot_sum;
	logic [IW-1:0]              slot_c;
	logic                       rd_en_c;
	logic                       self_c;
	logic [4:0]                 day_eff;
	logic [wera_pkg::DAY_W-1:0] days_c;

	always_comb begin
		day_eff   = (in_day == 5'd0) ? 5'd1 : in_day;
		days_c    = wera_pkg::days_before_month(in_month)
		            + wera_pkg::DAY_W'(day_eff) - wera_pkg::DAY_W'(1);
		// a threshold of zero acts as one
		m_c       = (thr_q == '0) ? wera_pkg::THR_W'(1) : thr_q;
		self_c    = (m_c == wera_pkg::THR_W'(1));
		count_nxt = (count_q == CW'(HISTORY_DEPTH)) ? count_q : count_q + CW'(1);
		rd_en_c   = XW'(m_c) <= XW'(count_nxt);
		// slot of the m-th most recent event; m-1 < depth whenever rd_en_c
		mm1       = XW'(m_c) - XW'(1);
		if (XW'(wr_idx_q) >= mm1) begin
			slot_sum = XW'(wr_idx_q) - mm1;
		end else begin
			slot_sum = XW'(wr_idx_q) + XW'(HISTORY_DEPTH) - mm1;
		end
		slot_c    = slot_sum[IW-1:0];
	end

	// ---- control registers ----
	logic fired_q;
	logic reached_c;
	logic first_c;
	logic ring_we;

	assign ring_we = adv && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			m_tvalid_q <= 1'b0;
			wr_idx_q   <= '0;
			count_q    <= '0;
			fired_q    <= 1'b0;
		end else begin
			if (adv) begin
				v_s1       <= s_tvalid;
				v_s2       <= v_s1;
				v_s3       <= v_s2;
				m_tvalid_q <= v_s3;
			end
			if (accept) begin
				wr_idx_q <= (wr_idx_q == IW'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_q + IW'(1);
				count_q  <= count_nxt;
			end
			if (ring_we && reached_c) begin
				fired_q <= 1'b1;
			end
		end
	end

	// ---- payload pipe ----
	logic [wera_pkg::DAY_W-1:0] days_s1;
	logic [4:0]                 hour_s1;
	logic [5:0]                 minute_s1;
	logic [5:0]                 second_s1;
	logic [IW-1:0]              idx_s1, idx_s2, idx_s3;
	logic [IW-1:0]              slot_s1, slot_s2, slot_s3;
	logic                       rd_en_s1, rd_en_s2, rd_en_s3;
	logic                       self_s1, self_s2, self_s3;
	logic [TW-1:0]              dsec_s2;
	logic [wera_pkg::HMS_W-1:0] hms_s2;
	logic [TW-1:0]              rdata_s2, rdata_s3;
	logic [TW-1:0]              t_s3;
	logic                       reached_q;
	logic                       first_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: captured fields
			days_s1   <= days_c;
			hour_s1   <= in_hour;
			minute_s1 <= in_minute;
			second_s1 <= in_second;
			idx_s1    <= wr_idx_q;
			slot_s1   <= slot_c;
			rd_en_s1  <= rd_en_c;
			self_s1   <= self_c;
			// s2: day seconds and time of day (constant multiplies)
			dsec_s2   <= TW'(days_s1 * wera_pkg::DAY_W'(1) * TW'(wera_pkg::SECS_PER_DAY));
			hms_s2    <= wera_pkg::HMS_W'(hour_s1 * wera_pkg::HMS_W'(wera_pkg::SECS_PER_HOUR))
			             + wera_pkg::HMS_W'(minute_s1 * wera_pkg::HMS_W'(wera_pkg::SECS_PER_MIN))
			             + wera_pkg::HMS_W'(second_s1);
			idx_s2    <= idx_s1;
			slot_s2   <= slot_s1;
			rd_en_s2  <= rd_en_s1;
			self_s2   <= self_s1;
			// s3: absolute time
			t_s3      <= dsec_s2 + TW'(hms_s2);
			rdata_s3  <= rdata_s2;
			idx_s3    <= idx_s2;
			slot_s3   <= slot_s2;
			rd_en_s3  <= rd_en_s2;
			self_s3   <= self_s2;
			// output register
			reached_q <= reached_c;
			first_q   <= first_c;
		end
	end

	// ---- history ring: read at s1->s2, write at s3 ----
	wera_ring #(
		.DEPTH (HISTORY_DEPTH),
		.IW    (IW)
	) u_ring (
		.clk      (clk),
		.we       (ring_we),
		.waddr    (idx_s3),
		.wdata    (t_s3),
		.re       (adv),
		.raddr    (slot_s1),
		.rdata_s2 (rdata_s2)
	);

	// ---- forwarding cells: the last writes that the ring read missed ----
	logic                cv    [NC+1];
	logic [IW-1:0]       cidx  [NC+1];
	logic [TW-1:0]       ct    [NC+1];
	wera_pkg::fwd_t      chain [NC+1];

	assign cv[0]    = 1'b1;
	assign cidx[0]  = idx_s3;
	assign ct[0]    = t_s3;
	assign chain[0] = '{hit: 1'b0, t: '0};

	for (genvar k = 0; k < NC; k++) begin : g_cell
		wera_cell #(
			.IW (IW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ring_we),
			.up_valid  (cv[k]),
			.up_idx    (cidx[k]),
			.up_time   (ct[k]),
			.dn_valid  (cv[k+1]),
			.dn_idx    (cidx[k+1]),
			.dn_time   (ct[k+1]),
			.lookup    (slot_s3),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1])
		);
	end

	// ---- s3: window compare ----
	logic [TW-1:0] older;

	always_comb begin
		if (self_s3) begin
			older = t_s3;
		end else if (chain[NC].hit) begin
			older = chain[NC].t;
		end else begin
			older = rdata_s3;
		end
		reached_c = rd_en_s3 && (((TW+1)'(older) + (TW+1)'(win_q)) > (TW+1)'(t_s3));
		first_c   = reached_c && !fired_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(wera_pkg::OUT_TDATA_W-2){1'b0}}, first_q, reached_q};

	// ---- assertions ----
	a_fired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q |=> fired_q)
		else $error("alarm fired flag cleared");

	a_fire_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_we && reached_c) |=> fired_q)
		else $error("reached event did not set fired flag");

	a_first_implies_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && first_q) |-> reached_q)
		else $error("first_reach without reached");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(HISTORY_DEPTH))
		else $error("fill count beyond history depth");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (count_q == CW'(HISTORY_DEPTH))) |=> (count_q == CW'(HISTORY_DEPTH)))
		else $error("fill count left saturation");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for windowed_event_rate_alarm
// Drives calendar time stamps into the input stream. A local alarm predictor
// works out reached/first_reach for every accepted transfer. The results seen
// on the output stream are checked against it in order, under random idling
// on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int          RING_DEPTH   = wera_pkg::HISTORY_DEPTH_DEF;
	localparam int unsigned YEAR_SECONDS = 366 * wera_pkg::SECS_PER_DAY;
	localparam int          HOLD_AT      = 150;	// result count that starts the long hold-off
	localparam int          HOLD_CYCLES  = 80;
	localparam int          DRAIN_CYCLES = 20;	// pipe is 4 deep, leave plenty of margin

	// same layout as s_tdata, month in the low bits
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
	} stamp_t;

	// same layout as m_tdata[1:0]
	typedef struct packed {
		logic first_reach;
		logic reached;
	} alarm_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	wire                              s_tready;
	logic [wera_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	wire                              m_tvalid;
	logic                             m_tready  = 1'b0;
	wire  [wera_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_we    = 1'b0;
	logic [wera_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [wera_pkg::WIN_W-1:0]       cfg_wdata = '0;

	windowed_event_rate_alarm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// alarm predictor state
	logic [wera_pkg::TIME_W-1:0] ring_times [RING_DEPTH];
	int unsigned                 ring_head     = 0;
	int unsigned                 ring_fill     = 0;
	bit                          alarm_fired   = 1'b0;
	logic [wera_pkg::WIN_W-1:0]  window_now    = wera_pkg::WINDOW_RESET;
	logic [wera_pkg::THR_W-1:0]  threshold_now = wera_pkg::THRESHOLD_RESET;

	stamp_t      pending_stamps [$];
	alarm_t      expected_alarms [$];
	int          mismatch_count = 0;
	int          results_seen   = 0;
	bit          calm           = 1'b0;	// no idling on either side while set
	int unsigned t_cursor;

	function automatic void queue_stamp(stamp_t s);
		pending_stamps.insert(pending_stamps.size(), s);
	endfunction

	function automatic int unsigned days_to_month(int unsigned mo);
		case (mo)
			1:       return 0;
			2:       return 31;
			3:       return 60;
			4:       return 91;
			5:       return 121;
			6:       return 152;
			7:       return 182;
			8:       return 213;
			9:       return 244;
			10:      return 274;
			11:      return 305;
			default: return 335;
		endcase
	endfunction

	// out-of-range month clamps, day zero reads as day 1, the rest just adds up
	function automatic int unsigned seconds_of_year(stamp_t s);
		int unsigned mo;
		int unsigned dy;
		mo = s.month;
		dy = s.day;
		if (mo == 0) mo = 1;
		else if (mo > 12) mo = 12;
		if (dy == 0) dy = 1;
		return (days_to_month(mo) + dy - 1) * wera_pkg::SECS_PER_DAY
			+ s.hour * wera_pkg::SECS_PER_HOUR
			+ s.minute * wera_pkg::SECS_PER_MIN + s.second;
	endfunction

	// canonical calendar form of a second of the year
	function automatic stamp_t stamp_of(int unsigned t);
		stamp_t      s;
		int unsigned doy;
		int unsigned rest;
		int unsigned mo;
		doy  = t / wera_pkg::SECS_PER_DAY;
		rest = t % wera_pkg::SECS_PER_DAY;
		mo   = 12;
		while (days_to_month(mo) > doy) mo--;
		s.month  = 4'(mo);
		s.day    = 5'(doy - days_to_month(mo) + 1);
		s.hour   = 5'(rest / wera_pkg::SECS_PER_HOUR);
		s.minute = 6'((rest % wera_pkg::SECS_PER_HOUR) / wera_pkg::SECS_PER_MIN);
		s.second = 6'(rest % wera_pkg::SECS_PER_MIN);
		return s;
	endfunction

	function automatic stamp_t stamp(int mo, int dy, int hr, int mi, int se);
		stamp_t s;
		s.month  = 4'(mo);
		s.day    = 5'(dy);
		s.hour   = 5'(hr);
		s.minute = 6'(mi);
		s.second = 6'(se);
		return s;
	endfunction

	// store the new time, then look at the threshold-th most recent one
	function automatic alarm_t predict_alarm(stamp_t s);
		alarm_t      a;
		int unsigned t;
		int unsigned here;
		int unsigned need;
		int unsigned slot;
		t    = seconds_of_year(s);
		here = ring_head;
		ring_times[here] = wera_pkg::TIME_W'(t);
		ring_head = (here + 1) % RING_DEPTH;
		if (ring_fill < RING_DEPTH) ring_fill++;
		need = (threshold_now == 0) ? 1 : threshold_now;
		a = '0;
		if (need <= ring_fill) begin
			slot = (here + RING_DEPTH - (need - 1)) % RING_DEPTH;
			a.reached = (ring_times[slot] + window_now) > t;
		end
		a.first_reach = a.reached && !alarm_fired;
		if (a.reached) alarm_fired = 1'b1;
		return a;
	endfunction

	function automatic int idle_draw();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic void flag_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
	endfunction

	// sender: one stamp per transfer, random gap before the next
	stamp_t on_bus;
	int     send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			// transfer taken at this edge: predict with the registers as they stand
			if (s_tvalid)
				expected_alarms.insert(expected_alarms.size(), predict_alarm(on_bus));
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_stamps.size() > 0) begin
				on_bus = pending_stamps.pop_front();
				s_tdata  <= wera_pkg::IN_TDATA_W'(on_bus);
				s_tvalid <= 1'b1;
				send_gap = idle_draw();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: checks each result, random stall after it, one long hold-off
	int     stall_left;
	int     hold_left;
	alarm_t got;
	alarm_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = alarm_t'(m_tdata[1:0]);
				results_seen++;
				if (expected_alarms.size() == 0) begin
					flag_failure($sformatf("result with none pending: reached=%b first_reach=%b",
						got.reached, got.first_reach));
				end else begin
					want = expected_alarms.pop_front();
					if (got.reached !== want.reached)
						flag_failure($sformatf("result %0d reached: expected %b, got %b",
							results_seen, want.reached, got.reached));
					if (got.first_reach !== want.first_reach)
						flag_failure($sformatf("result %0d first_reach: expected %b, got %b",
							results_seen, want.first_reach, got.first_reach));
				end
				stall_left = idle_draw();
				// sender keeps offering during this, so the pipe fills and s_tready drops
				if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_left > 0) hold_left--;
			m_tready <= (stall_left == 0 && hold_left == 0);
		end
	end

	// sampled mid-cycle so the edge's updates have all settled
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_stamps.size() != 0 || s_tvalid || expected_alarms.size() != 0);
	endtask

	task automatic write_reg(logic [wera_pkg::CFG_IDX_W-1:0] idx,
			logic [wera_pkg::WIN_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// only called with the block idle
	task automatic set_registers(int unsigned win, int unsigned thr);
		write_reg(wera_pkg::REG_WINDOW, wera_pkg::WIN_W'(win));
		window_now = wera_pkg::WIN_W'(win);
		write_reg(wera_pkg::REG_THRESHOLD, wera_pkg::WIN_W'(wera_pkg::THR_W'(thr)));
		threshold_now = wera_pkg::THR_W'(thr);
	endtask

	// mostly ordered stamps spaced so the count hovers near the threshold,
	// with some raw 26-bit noise and the odd jump across a whole window
	task automatic run_phase(int unsigned win, int unsigned thr, int count, bit quiet);
		int unsigned spacing;
		int unsigned step;
		set_registers(win, thr);
		calm = quiet;
		spacing = 2 * win / ((thr == 0) ? 1 : thr) + 1;
		repeat (count) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_stamp(stamp_t'(26'($urandom())));
			end else begin
				if ($urandom_range(0, 19) == 0) step = $urandom_range(0, 2 * win + 1);
				else step = $urandom_range(0, spacing);
				t_cursor += step;
				if (t_cursor >= YEAR_SECONDS)
					t_cursor = $urandom_range(0, wera_pkg::SECS_PER_DAY);
				queue_stamp(stamp_of(t_cursor));
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: 60 s window, threshold 1; first stamp fires the alarm
		queue_stamp(stamp(1, 1, 0, 0, 0));
		queue_stamp(stamp(1, 1, 0, 0, 0));
		queue_stamp(stamp(0, 0, 0, 0, 5));		// month and day zero
		queue_stamp(stamp(2, 29, 12, 30, 30));	// leap day
		queue_stamp(stamp(12, 31, 23, 59, 59));
		queue_stamp(stamp(13, 31, 23, 59, 59));	// reads as December
		queue_stamp(stamp(14, 31, 31, 63, 63));	// h/m/s past range
		queue_stamp(stamp(15, 31, 31, 63, 63));	// largest sum
		queue_stamp(stamp(1, 1, 0, 0, 0));		// back in time
		queue_stamp(stamp(3, 0, 0, 0, 0));
		wait_drained();

		// zero window and zero threshold: never reached when in order
		set_registers(0, 0);
		queue_stamp(stamp(3, 1, 0, 0, 0));
		queue_stamp(stamp(3, 1, 0, 0, 0));
		queue_stamp(stamp(3, 1, 0, 0, 1));
		wait_drained();

		// widest fields: threshold beyond the ring
		set_registers(2 ** wera_pkg::WIN_W - 1, 2 ** wera_pkg::THR_W - 1);
		queue_stamp(stamp(4, 1, 0, 0, 0));
		queue_stamp(stamp(4, 1, 0, 0, 1));
		wait_drained();

		// one-second window, two events: same second hits, next second misses
		set_registers(1, 2);
		queue_stamp(stamp(5, 5, 5, 5, 5));
		queue_stamp(stamp(5, 5, 5, 5, 5));
		queue_stamp(stamp(5, 5, 5, 5, 6));
		queue_stamp(stamp(5, 5, 5, 5, 6));
		wait_drained();

		// full-day window, full-ring threshold
		set_registers(wera_pkg::SECS_PER_DAY, RING_DEPTH);
		queue_stamp(stamp(6, 1, 0, 0, 0));
		queue_stamp(stamp(6, 2, 0, 0, 0));
		wait_drained();

		t_cursor = seconds_of_year(stamp(6, 2, 0, 0, 0));
		run_phase(60, 3, 90, 1'b0);
		run_phase(1, 1, 60, 1'b1);		// the long hold-off lands here
		run_phase(wera_pkg::SECS_PER_DAY, 40, 80, 1'b0);
		run_phase(wera_pkg::SECS_PER_HOUR, 8, 90, 1'b0);
		run_phase(0, 0, 40, 1'b0);
		run_phase($urandom_range(1, 600), $urandom_range(1, 16), 100, 1'b0);
		run_phase(300, RING_DEPTH, 60, 1'b0);
		run_phase(2 ** wera_pkg::WIN_W - 1, 300, 130, 1'b1);

		// anything arriving now is unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_alarms.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
